>>> hw/rtl/cidr_al_pkg.sv
// shared types, constants and mask helper for the ipv4 cidr allow list
package cidr_al_pkg;

    localparam int ADDR_W         = 32;
    localparam int PREFIX_W       = 6;
    localparam int COUNT_W        = 5;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [ADDR_W-1:0]   ADDR_ONES   = '1;
    localparam logic [PREFIX_W-1:0] FULL_PREFIX = PREFIX_W'(ADDR_W);

    typedef enum logic {
        REQ_ADD   = 1'b0,
        REQ_CHECK = 1'b1
    } t_req_type;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FULL = 1'b1
    } t_status;

    typedef struct packed {
        t_req_type           req_type;
        logic [ADDR_W-1:0]   address;
        logic [PREFIX_W-1:0] prefix_len;
    } t_req;

    typedef struct packed {
        logic               allowed;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] mask;
    } t_entry;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] prefix);
        logic [PREFIX_W-1:0] p;
        p = (prefix > FULL_PREFIX) ? FULL_PREFIX : prefix;
        return ~(ADDR_ONES >> p);
    endfunction

endpackage

>>> hw/rtl/cidr_al_table.sv
// entry storage: one write port, one registered read port
module cidr_al_table #(
    parameter int MAX_ENTRIES = cidr_al_pkg::MAX_ENTRIES_DEF,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  cidr_al_pkg::t_entry i_wr_data,
    input  logic [IDX_W-1:0]    i_rd_idx,
    output cidr_al_pkg::t_entry o_rd_data
);

    cidr_al_pkg::t_entry r_mem [MAX_ENTRIES];
    cidr_al_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/ipv4_cidr_allow_list.sv
// top level of the ipv4 cidr allow list: request sequencer, entry scan and result register
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------
//  request | i_valid | o_ready | i_req  (req_type, address, prefix_len)
//  result  | o_valid | i_ready | o_rsp  (allowed, status, entry_count)
//
// add: the entry is written in S_ADD, then S_DONE loads the result; a full table goes straight to S_DONE
// check: S_SCAN compares the stored entries, then S_DONE loads the result; an empty table goes straight to S_DONE
// the scan reads one entry per cycle through the table read port into one compare
// a check stops early on the first matching entry
// o_ready is high only while no request is in flight; a held result stalls the last step
// reset clears the entry count and all control state, table contents are left as is
module ipv4_cidr_allow_list #(
    parameter int MAX_ENTRIES = cidr_al_pkg::MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cidr_al_pkg::t_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output cidr_al_pkg::t_rsp o_rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    cidr_al_pkg::t_req   r_req, n_req;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_allow, n_allow;
    cidr_al_pkg::t_status r_status, n_status;
    cidr_al_pkg::t_rsp   r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                wr_en;
    cidr_al_pkg::t_entry wr_data;
    cidr_al_pkg::t_entry rd_data;
    logic                issue;
    logic                match;
    logic                out_free;

    cidr_al_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_count[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_idx  (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign wr_en        = (r_state == S_ADD);
    assign wr_data.mask = cidr_al_pkg::prefix_mask(r_req.prefix_len);
    assign wr_data.net  = r_req.address & wr_data.mask;

    assign issue    = (r_state == S_SCAN) && (r_idx < r_count);
    assign match    = r_cmp_vld && ((r_req.address & rd_data.mask) == rd_data.net);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cmp_vld   = 1'b0;
        n_allow     = r_allow;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req    = i_req;
                    n_allow  = 1'b0;
                    n_status = cidr_al_pkg::STATUS_OK;
                    n_idx    = '0;
                    if (i_req.req_type == cidr_al_pkg::REQ_ADD) begin
                        if (r_count >= CNT_MAX) begin
                            n_status = cidr_al_pkg::STATUS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_ADD;
                        end
                    end else if (r_count == '0) begin
                        n_allow = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_ADD: begin
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_SCAN: begin
                n_cmp_vld = issue;
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (match) begin
                    n_allow   = 1'b1;
                    n_cmp_vld = 1'b0;
                    n_state   = S_DONE;
                end else if (!issue && !r_cmp_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.allowed     = r_allow;
                    n_out.status      = r_status;
                    n_out.entry_count = cidr_al_pkg::COUNT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
        r_req    <= n_req;
        r_allow  <= n_allow;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("entry count above table depth");

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == S_SCAN))
        else $error("compare pending outside scan");

    a_full_not_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == cidr_al_pkg::STATUS_FULL)) |-> !o_rsp.allowed)
        else $error("rejected add reports allowed");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |=> (r_count == $past(r_count) + 1'b1))
        else $error("add did not raise the count");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the ipv4 cidr allow list: directed and random add/check traffic
module tb_top;

    localparam int CLK_HALF    = 1;
    localparam int RST_CYCLES  = 9;
    localparam int RAND_ITEMS  = 1450;
    localparam int CHUNK_ITEMS = 50;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam int AW          = cidr_al_pkg::ADDR_W;
    localparam int PW          = cidr_al_pkg::PREFIX_W;
    localparam int DEPTH       = cidr_al_pkg::MAX_ENTRIES_DEF;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    cidr_al_pkg::t_req i_req;
    logic              o_valid;
    logic              i_ready;
    cidr_al_pkg::t_rsp o_rsp;

    logic [AW-1:0]     net_mem [DEPTH];
    logic [AW-1:0]     mask_mem [DEPTH];
    int                stored_cnt;
    cidr_al_pkg::t_rsp pending_verdicts[$];
    int                err_count;
    int                rsp_seen;
    int                cycles;
    int                rsp_gap_left;
    bit                idle_on;
    bit                hold_request;
    bit                rsp_hold_on;

    ipv4_cidr_allow_list u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [AW-1:0] cidr_mask(input logic [PW-1:0] plen);
        logic [AW-1:0] m;
        int            bits;
        bits = (plen > AW) ? AW : int'(plen);
        m = '0;
        for (int b = 0; b < bits; b++) m[AW-1-b] = 1'b1;
        return m;
    endfunction

    function automatic cidr_al_pkg::t_rsp lookup_verdict(input cidr_al_pkg::t_req req);
        cidr_al_pkg::t_rsp r;
        logic [AW-1:0]     m;
        r = '0;
        if (req.req_type == cidr_al_pkg::REQ_ADD) begin
            if (stored_cnt >= DEPTH) begin
                r.status = cidr_al_pkg::STATUS_FULL;
            end else begin
                m = cidr_mask(req.prefix_len);
                net_mem[stored_cnt]  = req.address & m;
                mask_mem[stored_cnt] = m;
                stored_cnt++;
            end
        end else begin
            r.allowed = (stored_cnt == 0);
            for (int e = 0; e < stored_cnt; e++) begin
                if ((req.address & mask_mem[e]) == net_mem[e]) r.allowed = 1'b1;
            end
        end
        r.entry_count = cidr_al_pkg::COUNT_W'(stored_cnt);
        return r;
    endfunction

    function automatic cidr_al_pkg::t_req make_req(input cidr_al_pkg::t_req_type kind,
                                                   input logic [AW-1:0] addr,
                                                   input logic [PW-1:0] plen);
        cidr_al_pkg::t_req r;
        r.req_type   = kind;
        r.address    = addr;
        r.prefix_len = plen;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on result transfer %0d: %s got %0d expected %0d",
                 rsp_seen, field, got, want);
        err_count++;
    endtask

    task automatic send_req(input cidr_al_pkg::t_req req);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (!o_ready);
        pending_verdicts.push_back(lookup_verdict(req));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // result side: one compare per transfer
    always @(posedge i_clk) begin
        cidr_al_pkg::t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            rsp_seen++;
            if (pending_verdicts.size() == 0) begin
                $display("unexpected result transfer %0d", rsp_seen);
                err_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_rsp.allowed !== want.allowed)
                    report_mismatch("allowed", o_rsp.allowed, want.allowed);
                if (o_rsp.status !== want.status)
                    report_mismatch("status", o_rsp.status, want.status);
                if (o_rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_rsp.entry_count, want.entry_count);
            end
            rsp_gap_left = idle_on ? $urandom_range(0, 6) : 0;
        end
    end

    always @(negedge i_clk) begin
        if (rsp_hold_on) begin
            i_ready <= 1'b0;
        end else if (rsp_gap_left > 0) begin
            i_ready <= 1'b0;
            rsp_gap_left--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // long receiver stall
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            rsp_hold_on  = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rsp_hold_on  = 1'b0;
        end
    end

    function automatic logic [AW-1:0] pick_peer();
        logic [AW-1:0] addr;
        int            sel;
        int            ones;
        int            idx;
        addr = $urandom;
        sel  = $urandom_range(0, 2);
        if (stored_cnt > 0 && sel != 0) begin
            idx  = $urandom_range(0, stored_cnt - 1);
            addr = net_mem[idx] | (addr & ~mask_mem[idx]);
            ones = $countones(mask_mem[idx]);
            if (sel == 2 && ones > 0)
                addr[AW - 1 - $urandom_range(0, ones - 1)] ^= 1'b1;
        end
        return addr;
    endfunction

    task automatic test_empty_table();
        idle_on = 1'b1;
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h0000_0000, 6'd0));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'hFFFF_FFFF, 6'd63));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h5A5A_A5A5, 6'd32));
    endtask

    task automatic test_prefix_forms();
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'hFFFF_FFFF, 6'd32));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'h0A00_0001, 6'd33));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'hC0A8_0101, 6'd63));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'h0000_0000, 6'd31));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'hFFFF_FFFF, 6'd1));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'hAC10_0000, 6'd12));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'h1234_5678, 6'd24));
    endtask

    task automatic test_peer_matches();
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h0A00_0001, 6'd0));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h0A00_0002, 6'd45));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h0000_0001, 6'd31));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'hAC1F_FFFF, 6'd7));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h1234_5600, 6'd24));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h1234_5700, 6'd24));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h7FFF_FFFF, 6'd63));
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % CHUNK_ITEMS == 0) idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0 && stored_cnt < DEPTH - 1)
                send_req(make_req(cidr_al_pkg::REQ_ADD, $urandom,
                                  PW'($urandom_range(2, 63))));
            else
                send_req(make_req(cidr_al_pkg::REQ_CHECK, pick_peer(), PW'($urandom)));
        end
    endtask

    task automatic test_result_stall();
        wait_drained();
        idle_on      = 1'b0;
        hold_request = 1'b1;
        for (int n = 0; n < 20; n++)
            send_req(make_req(cidr_al_pkg::REQ_CHECK, pick_peer(), PW'($urandom)));
        idle_on = 1'b1;
    endtask

    task automatic test_table_full();
        wait_drained();
        while (stored_cnt < DEPTH - 1)
            send_req(make_req(cidr_al_pkg::REQ_ADD, $urandom, PW'($urandom_range(16, 32))));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h0000_0002, 6'd0));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'hDEAD_BEEF, 6'd0));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'hFFFF_FFFF, 6'd63));
        send_req(make_req(cidr_al_pkg::REQ_ADD, 32'h0000_0000, 6'd0));
        send_req(make_req(cidr_al_pkg::REQ_ADD, $urandom, 6'd24));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h0000_0002, 6'd0));
        send_req(make_req(cidr_al_pkg::REQ_CHECK, 32'h7FFF_FFFF, 6'd32));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_req        = '0;
        stored_cnt   = 0;
        err_count    = 0;
        rsp_seen     = 0;
        cycles       = 0;
        rsp_gap_left = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        rsp_hold_on  = 1'b0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_prefix_forms();
        test_peer_matches();
        test_random_traffic();
        test_result_stall();
        test_table_full();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/cidr_al_pkg.sv
hw/rtl/cidr_al_table.sv
hw/rtl/ipv4_cidr_allow_list.sv
tb/sv/tb_top.sv
